### design/hid_report_to_key_events_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keyboard report event converter
// Concurrent checks on the clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef HID_REPORT_TO_KEY_EVENTS_TOP_ASSERT_SVH
`define HID_REPORT_TO_KEY_EVENTS_TOP_ASSERT_SVH

// Overlapping implication: cons must hold in the cycle that ante holds.
`define HRKE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrke: implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define HRKE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrke: next-cycle check failed");

`endif

### design/hrke_pkg.sv
// ---------------------------------------------------------------------------
// hrke_pkg
// Types, constants and register codes shared by the report event converter.
// ---------------------------------------------------------------------------
package hrke_pkg;

  localparam int CODE_W               = 8;
  localparam int MAX_SLOTS            = 7;
  localparam int NUM_MODS             = 4;
  localparam int NUM_EVENTS           = NUM_MODS + MAX_SLOTS;
  localparam int REPORT_BYTES_DEFAULT = 8;
  localparam int QUEUE_DEPTH          = 2;
  localparam int REG_INDEX_W          = 2;

  // Modifier byte bit masks.
  localparam logic [CODE_W-1:0] MOD_LCTRL  = 8'h01;
  localparam logic [CODE_W-1:0] MOD_LSHIFT = 8'h02;
  localparam logic [CODE_W-1:0] MOD_LALT   = 8'h04;
  localparam logic [CODE_W-1:0] MOD_RSHIFT = 8'h20;

  // Reset values of the event code registers.
  localparam logic [CODE_W-1:0] SHIFT_CODE_RESET = 8'h60;
  localparam logic [CODE_W-1:0] ALT_CODE_RESET   = 8'h61;
  localparam logic [CODE_W-1:0] CTRL_CODE_RESET  = 8'h62;

  // Event positions in emit order; also the packed modifier bit positions.
  localparam int EV_LSHIFT = 0;
  localparam int EV_RSHIFT = 1;
  localparam int EV_LALT   = 2;
  localparam int EV_LCTRL  = 3;
  localparam int EV_SLOT0  = 4;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SHIFT_CODE = 2'd0,
    REG_ALT_CODE   = 2'd1,
    REG_CTRL_CODE  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CODE_W-1:0] modifiers;
    logic [CODE_W-1:0] key_slot_1;
    logic [CODE_W-1:0] key_slot_2;
    logic [CODE_W-1:0] key_slot_3;
    logic [CODE_W-1:0] key_slot_4;
    logic [CODE_W-1:0] key_slot_5;
    logic [CODE_W-1:0] key_slot_6;
    logic [CODE_W-1:0] key_slot_7;
  } report_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic              is_press;
    logic              last_event;
  } key_event_t;

  // All events of one report, classified and waiting to be sent.
  typedef struct packed {
    logic [NUM_EVENTS-1:0]             pending;
    logic [NUM_EVENTS-1:0]             press;
    logic [NUM_EVENTS-1:0][CODE_W-1:0] code;
  } ev_batch_t;

  typedef struct packed {
    logic      push;
    ev_batch_t batch;
  } batch_push_t;

endpackage

### design/hrke_front.sv
// ---------------------------------------------------------------------------
// hrke_front
// Compares each accepted report with the stored one and classifies events.
// ---------------------------------------------------------------------------
module hrke_front #(
  parameter int REPORT_BYTES = hrke_pkg::REPORT_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  hrke_pkg::report_t                report,
  input  logic                             cfg_wr,
  input  logic [hrke_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [hrke_pkg::CODE_W-1:0]      cfg_data,
  output hrke_pkg::batch_push_t            q_wr
);
  import hrke_pkg::*;

  localparam int SlotCount = (REPORT_BYTES - 1 < MAX_SLOTS) ? REPORT_BYTES - 1 : MAX_SLOTS;

  logic [CODE_W-1:0]                shift_code;
  logic [CODE_W-1:0]                alt_code;
  logic [CODE_W-1:0]                ctrl_code;
  logic [NUM_MODS-1:0]              prev_mods;
  logic [NUM_MODS-1:0]              cur_mods;
  logic [MAX_SLOTS-1:0][CODE_W-1:0] prev_slots;
  logic [MAX_SLOTS-1:0][CODE_W-1:0] prev_slots_next;
  logic [MAX_SLOTS-1:0][CODE_W-1:0] cur_slots;
  ev_batch_t                        batch;

  assign cur_slots = {report.key_slot_7, report.key_slot_6, report.key_slot_5,
                      report.key_slot_4, report.key_slot_3, report.key_slot_2,
                      report.key_slot_1};

  assign cur_mods[EV_LSHIFT] = |(report.modifiers & MOD_LSHIFT);
  assign cur_mods[EV_RSHIFT] = |(report.modifiers & MOD_RSHIFT);
  assign cur_mods[EV_LALT]   = |(report.modifiers & MOD_LALT);
  assign cur_mods[EV_LCTRL]  = |(report.modifiers & MOD_LCTRL);

  always_comb begin
    batch = '0;
    prev_slots_next = prev_slots;
    for (int m = 0; m < NUM_MODS; m++) begin
      batch.pending[m] = cur_mods[m] ^ prev_mods[m];
      batch.press[m]   = cur_mods[m];
    end
    batch.code[EV_LSHIFT] = shift_code;
    batch.code[EV_RSHIFT] = shift_code;
    batch.code[EV_LALT]   = alt_code;
    batch.code[EV_LCTRL]  = ctrl_code;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < SlotCount) begin
        // A cleared slot releases its old code; any other change presses the new one.
        batch.pending[EV_SLOT0 + i] = (cur_slots[i] != prev_slots[i]);
        batch.press[EV_SLOT0 + i]   = (cur_slots[i] != '0);
        batch.code[EV_SLOT0 + i]    = (cur_slots[i] != '0) ? cur_slots[i] : prev_slots[i];
        prev_slots_next[i]          = cur_slots[i];
      end
    end
  end

  assign q_wr.push  = accept && (batch.pending != '0);
  assign q_wr.batch = batch;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_code <= SHIFT_CODE_RESET;
      alt_code   <= ALT_CODE_RESET;
      ctrl_code  <= CTRL_CODE_RESET;
      prev_mods  <= '0;
      prev_slots <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == REG_SHIFT_CODE) begin
          shift_code <= cfg_data;
        end
        if (cfg_index == REG_ALT_CODE) begin
          alt_code <= cfg_data;
        end
        if (cfg_index == REG_CTRL_CODE) begin
          ctrl_code <= cfg_data;
        end
      end
      if (accept) begin
        prev_mods  <= cur_mods;
        prev_slots <= prev_slots_next;
      end
    end
  end

endmodule

### design/hrke_queue.sv
// ---------------------------------------------------------------------------
// hrke_queue
// Short queue of classified event batches between front and back.
// ---------------------------------------------------------------------------
module hrke_queue #(
  parameter int DEPTH = hrke_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hrke_pkg::batch_push_t wr,
  input  logic                  rd,
  output hrke_pkg::ev_batch_t   rd_batch,
  output logic                  full,
  output logic                  not_empty
);
  import hrke_pkg::*;

  localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountW = $clog2(DEPTH + 1);

  ev_batch_t          mem [DEPTH];
  logic [AddrW-1:0]   wr_ptr;
  logic [AddrW-1:0]   rd_ptr;
  logic [CountW-1:0]  count;
  logic               do_wr;
  logic               do_rd;

  assign full      = (count == CountW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr.push && !full;
  assign do_rd     = rd && not_empty;
  assign rd_batch  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr.batch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AddrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AddrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/hrke_back.sv
// ---------------------------------------------------------------------------
// hrke_back
// Sends the pending events of one batch, lowest position first, one a cycle while the output is free.
// ---------------------------------------------------------------------------
module hrke_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  hrke_pkg::ev_batch_t  q_batch,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output hrke_pkg::key_event_t key_event
);
  import hrke_pkg::*;

  logic [NUM_EVENTS-1:0]             cur_pending;
  logic [NUM_EVENTS-1:0]             cur_press;
  logic [NUM_EVENTS-1:0][CODE_W-1:0] cur_code;
  logic [NUM_EVENTS-1:0]             sel_oh;
  logic [NUM_EVENTS-1:0]             rem;
  logic [CODE_W-1:0]                 sel_code;
  logic                              sel_press;
  logic                              out_valid;
  logic                              out_free;
  logic                              emit;
  key_event_t                        out_item;

  // Isolate the lowest pending event.
  assign sel_oh = cur_pending & ~(cur_pending - 1'b1);
  assign rem    = cur_pending & ~sel_oh;

  always_comb begin
    sel_code  = '0;
    sel_press = 1'b0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      sel_code  = sel_code | (sel_oh[i] ? cur_code[i] : '0);
      sel_press = sel_press | (sel_oh[i] & cur_press[i]);
    end
  end

  assign out_free = !out_valid || pop;
  assign emit     = (cur_pending != '0) && out_free;
  assign q_rd     = q_not_empty && ((cur_pending == '0) || (emit && (rem == '0)));

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_press <= q_batch.press;
      cur_code  <= q_batch.code;
    end
    if (emit) begin
      out_item.event_code <= sel_code;
      out_item.is_press   <= sel_press;
      out_item.last_event <= (rem == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pending <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_rd) begin
        cur_pending <= q_batch.pending;
      end else if (emit) begin
        cur_pending <= rem;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty     = !out_valid;
  assign key_event = out_item;

endmodule

### design/hid_report_to_key_events_top.sv
// ---------------------------------------------------------------------------
// hid_report_to_key_events_top
// Turns keyboard reports into key press and release transactions.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake          Payload                 Direction
//  report    push / full        modifiers, 7 key slots  in
//  key_event empty / pop        code, press, last flag  out
//  config    cfg_wr             cfg_index, cfg_data     in
//
// A report is taken in the cycle it is pushed while full is low; the front
// classifies it at once and places its events in a two-entry queue.
// With the back idle, the first event of a report goes from its queue entry
// through the back's pending register into the output register.
// The back sends one event transaction per cycle while its output is free;
// a report has at most eleven events, and the next batch follows with
// no gap. The output register is refilled in the cycle its event is taken,
// so a steady pop sees one event per cycle; while an event waits untaken,
// the back stalls.
// A report that changes nothing gives no transaction and is not queued.
// Reset is synchronous and clears the stored report, the queue, the output
// and restores the default event codes.
// ---------------------------------------------------------------------------
module hid_report_to_key_events_top #(
  parameter int REPORT_BYTES = hrke_pkg::REPORT_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH  = hrke_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  hrke_pkg::report_t                report,
  output logic                             empty,
  input  logic                             pop,
  output hrke_pkg::key_event_t             key_event,
  input  logic                             cfg_wr,
  input  logic [hrke_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [hrke_pkg::CODE_W-1:0]      cfg_data
);
  import hrke_pkg::*;

`include "hid_report_to_key_events_top_assert.svh"

  batch_push_t q_wr;
  ev_batch_t   q_batch;
  logic        q_full;
  logic        q_not_empty;
  logic        q_rd;
  logic        accept;

  // A report transaction completes whenever the queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  hrke_front #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .report   (report),
    .cfg_wr   (cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_wr     (q_wr)
  );

  hrke_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .rd       (q_rd),
    .rd_batch (q_batch),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  hrke_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_batch    (q_batch),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .key_event  (key_event)
  );

  // The events of one report leave back to back: after a non-final event is
  // taken, the next one is already in the output register.
  `HRKE_ASSERT_NEXT(a_burst_contiguous, clk, rst, pop && !empty && !key_event.last_event, !empty)

  // Only batches with at least one event ever reach the back.
  `HRKE_ASSERT_IMPL(a_batch_not_blank, clk, rst, q_rd, q_batch.pending != '0)

  // Right after reset nothing is waiting and the input side is open.
  `HRKE_ASSERT_IMPL(a_reset_clean, clk, rst, $past(rst), empty && !full)

endmodule

### test/key_event_board_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// key_event_board_pkg
// Scoreboard for the keyboard report event converter. It predicts the key
// events that each accepted report causes and checks the delivered events
// against them in order.
// ---------------------------------------------------------------------------
package key_event_board_pkg;

  import hrke_pkg::*;

  // Key slots compared per report, capped at the slots the report carries.
  localparam int SLOTS = (REPORT_BYTES_DEFAULT - 1 < MAX_SLOTS) ?
                         REPORT_BYTES_DEFAULT - 1 : MAX_SLOTS;

  // Console output is capped so that a badly broken block cannot flood it.
  localparam int unsigned PRINT_CAP = 200;

  class key_event_board;
    logic [CODE_W-1:0]                shift_code;
    logic [CODE_W-1:0]                alt_code;
    logic [CODE_W-1:0]                ctrl_code;
    logic [NUM_MODS-1:0]              held_mods;
    logic [MAX_SLOTS-1:0][CODE_W-1:0] held_keys;  // entry 0 is key slot 1
    key_event_t                       awaited[$];
    int unsigned                      mismatches;
    int unsigned                      delivered;

    function new();
      shift_code = SHIFT_CODE_RESET;
      alt_code   = ALT_CODE_RESET;
      ctrl_code  = CTRL_CODE_RESET;
      held_mods  = '0;
      held_keys  = '0;
      mismatches = 0;
      delivered  = 0;
    endfunction

    function int unsigned waiting();
      return awaited.size();
    endfunction

    // Writes to an index with no register behind it change nothing.
    function void set_code(logic [REG_INDEX_W-1:0] index, logic [CODE_W-1:0] data);
      case (index)
        REG_SHIFT_CODE: shift_code = data;
        REG_ALT_CODE:   alt_code   = data;
        REG_CTRL_CODE:  ctrl_code  = data;
        default: ;
      endcase
    endfunction

    // Works out the events of one accepted report and queues them.
    function void note_report(report_t r);
      logic [NUM_MODS-1:0]              mods;
      logic [MAX_SLOTS-1:0][CODE_W-1:0] keys;
      key_event_t                       ev;
      key_event_t                       batch[$];
      int                               m;
      int                               s;

      mods[EV_LSHIFT] = |(r.modifiers & MOD_LSHIFT);
      mods[EV_RSHIFT] = |(r.modifiers & MOD_RSHIFT);
      mods[EV_LALT]   = |(r.modifiers & MOD_LALT);
      mods[EV_LCTRL]  = |(r.modifiers & MOD_LCTRL);
      keys = {r.key_slot_7, r.key_slot_6, r.key_slot_5, r.key_slot_4,
              r.key_slot_3, r.key_slot_2, r.key_slot_1};

      for (m = 0; m < NUM_MODS; m++) begin
        if (mods[m] != held_mods[m]) begin
          ev.event_code = (m == EV_LALT) ? alt_code :
                          (m == EV_LCTRL) ? ctrl_code : shift_code;
          ev.is_press   = mods[m];
          ev.last_event = 1'b0;
          batch.push_back(ev);
        end
      end
      held_mods = mods;

      // A cleared slot releases its old code; any other change presses the
      // new code and leaves the old one alone.
      for (s = 0; s < SLOTS; s++) begin
        if (keys[s] != held_keys[s]) begin
          ev.is_press   = (keys[s] != '0);
          ev.event_code = ev.is_press ? keys[s] : held_keys[s];
          ev.last_event = 1'b0;
          batch.push_back(ev);
        end
        held_keys[s] = keys[s];
      end

      if (batch.size() != 0) begin
        batch[batch.size() - 1].last_event = 1'b1;
      end
      foreach (batch[i]) begin
        awaited.push_back(batch[i]);
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_CAP) begin
        $display("mismatch: %s", msg);
      end
      mismatches++;
    endtask

    task check_event(key_event_t got);
      key_event_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("event %0d (code %h) arrived with none expected",
                                  delivered, got.event_code));
      end else begin
        want = awaited.pop_front();
        if (got.event_code !== want.event_code) begin
          report_mismatch($sformatf("event %0d: code %h, expected %h",
                                    delivered, got.event_code, want.event_code));
        end
        if (got.is_press !== want.is_press) begin
          report_mismatch($sformatf("event %0d: press %b, expected %b",
                                    delivered, got.is_press, want.is_press));
        end
        if (got.last_event !== want.last_event) begin
          report_mismatch($sformatf("event %0d: last %b, expected %b",
                                    delivered, got.last_event, want.last_event));
        end
      end
      delivered++;
    endtask
  endclass

endpackage

### test/tb_hid_report_to_key_events_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hid_report_to_key_events_top
// Drives keyboard reports into the event converter and checks every key
// event transaction against a scoreboard prediction. A directed opening
// covers modifier toggles, cleared and replaced slots, unchanged reports and
// field extremes; random phases with fresh event codes follow, with random
// gaps on the report side and random stalls on the event side in all but one phase.
// ---------------------------------------------------------------------------
module tb_hid_report_to_key_events_top;

  import hrke_pkg::*;
  import key_event_board_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int          RESET_CYCLES = 12;
  // Once every predicted event has come back the block is idle, since a
  // report that changes nothing is absorbed in the cycle it is taken. This
  // gap keeps the phases apart and gives a stray extra event time to show.
  localparam int          SETTLE       = 16;
  localparam int          PHASES       = 4;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          BUSY_PCT     = 32;
  // Register index with no register behind it; writes there must be ignored.
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  report_t    report    = '0;
  logic       pop       = 1'b0;
  logic       cfg_wr    = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0]      cfg_data  = '0;
  logic       full;
  logic       empty;
  key_event_t key_event;

  int          idle_pct = BUSY_PCT;  // shared by both sides; zero in the calm phase
  int unsigned cycles   = 0;
  report_t     last_sent = '0;
  logic [CODE_W-1:0] shared_code = '0;
  key_event_board board;

  hid_report_to_key_events_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .report    (report),
    .empty     (empty),
    .pop       (pop),
    .key_event (key_event),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost event ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Event side. The values sampled at the edge are the ones from before it,
  // so a transaction is taken exactly when pop was high and empty was low.
  // Pop is then redrawn once per edge, which gives random stalls.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      board.check_event(key_event);
    end
    pop <= ($urandom_range(99) >= idle_pct);
  end

  // Offers one report and returns at the edge where it is accepted. Push is
  // left high so that a following report can go out without a gap; during
  // idle cycles the payload carries junk that the block must ignore.
  task automatic send_report(report_t r);
    while ($urandom_range(99) < idle_pct) begin
      push   <= 1'b0;
      report <= report_t'({$urandom, $urandom});
      @(posedge clk);
    end
    push   <= 1'b1;
    report <= r;
    do @(posedge clk); while (full);
    board.note_report(r);
    last_sent = r;
  endtask

  // Stops sending and waits until every predicted event has come back, then
  // keeps the block quiet for a short gap.
  task automatic settle();
    push <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write enable is left high so that back-to-back writes stay clean.
  task automatic write_reg(logic [REG_INDEX_W-1:0] index, logic [CODE_W-1:0] data);
    cfg_wr    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    board.set_code(index, data);
  endtask

  // Sets all three event codes and pokes the unused index with junk.
  task automatic program_codes(logic [CODE_W-1:0] shift_val, logic [CODE_W-1:0] alt_val,
                               logic [CODE_W-1:0] ctrl_val);
    write_reg(REG_SHIFT_CODE, shift_val);
    write_reg(REG_ALT_CODE, alt_val);
    write_reg(REG_CTRL_CODE, ctrl_val);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_wr <= 1'b0;
  endtask

  // Random reports mostly look like typing: the previous report, maybe with a
  // modifier bit flipped and with up to two slots pressed, replaced or cleared.
  // Some repeat the previous report exactly, and some are pure noise.
  function automatic report_t next_report(report_t prev);
    report_t                          r;
    logic [MAX_SLOTS-1:0][CODE_W-1:0] keys;
    int                               pick;
    int                               slot;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return prev;
    end
    if (pick < 30) begin
      return report_t'({$urandom, $urandom});
    end
    r = prev;
    if ($urandom_range(1) != 0) begin
      r.modifiers = r.modifiers ^ (8'(1) << $urandom_range(7));
    end
    keys = {r.key_slot_7, r.key_slot_6, r.key_slot_5, r.key_slot_4,
            r.key_slot_3, r.key_slot_2, r.key_slot_1};
    repeat ($urandom_range(2)) begin
      slot = $urandom_range(SLOTS - 1);
      keys[slot] = ($urandom_range(1) != 0) ? '0 : 8'($urandom_range(255, 1));
    end
    {r.key_slot_7, r.key_slot_6, r.key_slot_5, r.key_slot_4,
     r.key_slot_3, r.key_slot_2, r.key_slot_1} = keys;
    return r;
  endfunction

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset event codes. It starts with a report
    // equal to the cleared stored one, then presses and releases everything.
    send_report('0);
    send_report('1);
    send_report('1);
    send_report('0);
    // Only the ignored modifier bits set: nothing happens.
    send_report({~(MOD_LCTRL | MOD_LSHIFT | MOD_LALT | MOD_RSHIFT), 56'h0});
    send_report({MOD_LSHIFT, 8'h04, 48'h0});
    // Right shift joins: a second press of the shared shift code.
    send_report({MOD_LSHIFT | MOD_RSHIFT, 8'h04, 48'h0});
    // Slot replaced: only the new code is pressed.
    send_report({MOD_LSHIFT | MOD_RSHIFT, 8'h05, 48'h0});
    // Slot cleared: the old code is released.
    send_report({MOD_LSHIFT | MOD_RSHIFT, 56'h0});
    send_report({MOD_LALT | MOD_LCTRL, 56'h0});
    send_report({MOD_LALT | MOD_LCTRL, 56'h00_00_00_01_00_00_80});
    send_report({8'h00, 56'h55_AA_55_AA_55_AA_55});
    send_report({8'h00, 56'hAA_55_AA_55_AA_55_AA});

    // Extreme codes, both ways round.
    settle();
    program_codes(8'h00, 8'hFF, 8'h00);
    send_report({8'hFF, 56'h0});
    send_report('0);
    settle();
    program_codes(8'hFF, 8'h00, 8'hFF);
    send_report({MOD_RSHIFT, 56'h0});
    send_report({MOD_LCTRL, 56'h0});
    send_report({MOD_LALT | MOD_LSHIFT, 56'h01_00_00_00_00_00_FF});
    send_report('0);

    // Random phases. Each starts with the pipe drained and new codes; the
    // third runs with no idling on either side and the last gives all three
    // modifier codes the same value.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == PHASES - 1) begin
        shared_code = 8'($urandom);
        program_codes(shared_code, shared_code, shared_code);
      end else begin
        program_codes(8'($urandom), 8'($urandom), 8'($urandom));
      end
      idle_pct = (p == 2) ? 0 : BUSY_PCT;
      repeat (PHASE_ITEMS) begin
        send_report(next_report(last_sent));
      end
    end
    idle_pct = BUSY_PCT;

    settle();
    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/hrke_pkg.sv
design/hrke_front.sv
design/hrke_queue.sv
design/hrke_back.sv
design/hid_report_to_key_events_top.sv
test/key_event_board_pkg.sv
test/tb_hid_report_to_key_events_top.sv
